[hw/rtl/chtab_pkg.sv]
// Package for the chained hash table core: bucket count, default sizes, command and status codes.
// Depends on nothing; imported by chained_hash_table_core.
`default_nettype none
package chtab_pkg;

  // bucket count is the Mersenne number (2 << BKT_ORDER) - 1, which the folding hash relies on
  localparam int unsigned BKT_ORDER        = 7;
  localparam int unsigned NUM_BUCKETS      = (2 << BKT_ORDER) - 1;
  localparam int unsigned DEF_POOL_ENTRIES = 256;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned VAL_W            = 64;
  localparam int unsigned COUNT_W          = 9;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_POP    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

endpackage
`default_nettype wire

[hw/rtl/chained_hash_table_core.sv]
// Chained hash table core: sequencer, bucket/entry memories and folding modulo unit.
// Depends on chtab_pkg.
`default_nettype none
// Command-driven key/value store with separate chaining over a fixed entry pool.
// A command is taken when start is high and busy low; busy then stays high until
// its single result appears for one cycle on out_valid, which cannot be stalled.
// Insert, remove and find first hash the key: one key byte per cycle is added
// into the remainder and reduced by one compare/subtract (a byte of the sign
// extension is worth nothing modulo 255). Insert uses the lowest free slot, or
// reports a full pool; remove and find stop on an empty bucket, else visit the
// chain entries, remove unlinking the first match (find always walks the whole
// chain); pop takes the lowest non-empty bucket, or reports an empty table; clear
// and unknown commands need no hash or walk. The result is shown in the cycle
// after the last busy cycle, and a new command can be started in that cycle. No
// clearing pass after reset: bucket and slot flags reset at once.
module chained_hash_table_core
  import chtab_pkg::*;
#(
  parameter int unsigned POOL_ENTRIES = DEF_POOL_ENTRIES
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                in_cmd,
  input  wire logic signed [KEY_W-1:0]   in_key,
  input  wire logic [VAL_W-1:0]          in_value,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [VAL_W-1:0]               out_value_out,
  output logic [COUNT_W-1:0]             out_entry_count
);

  localparam int unsigned IW  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned LW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned RW  = $clog2(NUM_BUCKETS + 1) + 1;
  localparam int unsigned CW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned FW  = BKT_ORDER + 1;
  localparam int unsigned NCH = KEY_W / FW;
  localparam int unsigned HCW = $clog2(NCH);
  localparam logic [LW-1:0] NONE     = LW'(POOL_ENTRIES);
  localparam logic [RW-1:0] MODULUS  = RW'(NUM_BUCKETS);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_ENTRIES - 1);
  localparam logic [BW-1:0] LAST_BKT = BW'(NUM_BUCKETS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_FREE, S_INS_A, S_INS_B, S_HEAD_RD, S_HEAD_LD,
    S_ENT_RD, S_ENT_CHK, S_UNLINK, S_BSCAN, S_MISC
  } state_t;

  // control and working registers
  state_t               state_r, state_nxt;
  logic [2:0]           cmd_r, cmd_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [HCW-1:0]       bit_cnt_r, bit_cnt_nxt;
  logic [BW-1:0]        bkt_r, bkt_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        cur_r, cur_nxt;
  logic [LW-1:0]        nx_r, nx_nxt;
  logic [LW-1:0]        pv_r, pv_nxt;
  logic                 hit_r, hit_nxt;
  logic [VAL_W-1:0]     hitval_r, hitval_nxt;
  logic                 pop_r, pop_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [POOL_ENTRIES-1:0] used_r, used_nxt;
  logic [NUM_BUCKETS-1:0]  nonempty_r, nonempty_nxt;

  // result registers
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [VAL_W-1:0]     out_val_r;
  logic [CW-1:0]        out_count_r;

  // finishing strobe from the sequencer
  logic                 fin;
  logic [1:0]           fin_status;
  logic [VAL_W-1:0]     fin_val;

  // memories and their registered read data
  logic [LW-1:0]    head_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
  logic [VAL_W-1:0] val_mem  [POOL_ENTRIES];
  logic [LW-1:0]    next_mem [POOL_ENTRIES];
  logic [LW-1:0]    prev_mem [POOL_ENTRIES];
  logic [LW-1:0]    head_rd_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic [LW-1:0]    next_rd_r;
  logic [LW-1:0]    prev_rd_r;

  // memory write ports
  logic             hd_we, ent_we, nxm_we, pvm_we;
  logic [BW-1:0]    hd_wa;
  logic [LW-1:0]    hd_wd;
  logic [IW-1:0]    nxm_wa, pvm_wa;
  logic [LW-1:0]    nxm_wd, pvm_wd;

  // modulo step: add one key byte, reduce once
  logic [FW-1:0]     key_chunk;
  logic [RW-1:0]     rem_sh;
  logic [RW-1:0]     rem_step;
  logic              key_match;

  assign key_chunk = key_r[bit_cnt_r*FW +: FW];
  assign rem_sh    = rem_r + RW'(key_chunk);
  assign rem_step  = (rem_sh >= MODULUS) ? (rem_sh - MODULUS) : rem_sh;
  assign key_match = pop_r || (key_rd_r == key_r);

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    rem_nxt      = rem_r;
    bit_cnt_nxt  = bit_cnt_r;
    bkt_nxt      = bkt_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    nx_nxt       = nx_r;
    pv_nxt       = pv_r;
    hit_nxt      = hit_r;
    hitval_nxt   = hitval_r;
    pop_nxt      = pop_r;
    count_nxt    = count_r;
    used_nxt     = used_r;
    nonempty_nxt = nonempty_r;
    fin          = 1'b0;
    fin_status   = ST_OK;
    fin_val      = '0;
    hd_we  = 1'b0; hd_wa  = bkt_r; hd_wd  = NONE;
    ent_we = 1'b0;
    nxm_we = 1'b0; nxm_wa = cur_r; nxm_wd = NONE;
    pvm_we = 1'b0; pvm_wa = cur_r; pvm_wd = NONE;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          val_nxt     = in_value;
          rem_nxt     = '0;
          bit_cnt_nxt = HCW'(NCH - 1);
          bkt_nxt     = '0;
          idx_nxt     = '0;
          hit_nxt     = 1'b0;
          hitval_nxt  = '0;
          pop_nxt     = (in_cmd == CMD_POP);
          unique case (in_cmd) inside
            CMD_INSERT, CMD_REMOVE, CMD_FIND: state_nxt = S_HASH;
            CMD_POP:                          state_nxt = S_BSCAN;
            default:                          state_nxt = S_MISC;
          endcase
        end
      end
      // one key byte per cycle through the shared add and compare/subtract
      S_HASH: begin
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          bkt_nxt   = rem_step[BW-1:0];
          state_nxt = (cmd_r == CMD_INSERT) ? S_FREE : S_HEAD_RD;
        end
      end
      // find the lowest free slot
      S_FREE: begin
        if (!used_r[idx_r]) begin
          cur_nxt   = idx_r;
          state_nxt = S_INS_A;
        end else if (idx_r == LAST_IDX) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
          state_nxt  = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      // write the new entry and push it at the bucket head
      S_INS_A: begin
        nx_nxt  = nonempty_r[bkt_r] ? head_rd_r : NONE;
        ent_we  = 1'b1;
        nxm_we  = 1'b1;
        nxm_wd  = nonempty_r[bkt_r] ? head_rd_r : NONE;
        pvm_we  = 1'b1;
        pvm_wd  = NONE;
        hd_we   = 1'b1;
        hd_wd   = LW'(cur_r);
        nonempty_nxt[bkt_r] = 1'b1;
        used_nxt[cur_r]     = 1'b1;
        count_nxt = count_r + 1'b1;
        state_nxt = S_INS_B;
      end
      // back-link the old head
      S_INS_B: begin
        if (nx_r != NONE) begin
          pvm_we = 1'b1;
          pvm_wa = nx_r[IW-1:0];
          pvm_wd = LW'(cur_r);
        end
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_HEAD_RD: begin
        if (!nonempty_r[bkt_r]) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_HEAD_LD;
        end
      end
      S_HEAD_LD: begin
        cur_nxt   = head_rd_r[IW-1:0];
        state_nxt = S_ENT_RD;
      end
      S_ENT_RD: state_nxt = S_ENT_CHK;
      // check one chain entry, then advance or stop
      S_ENT_CHK: begin
        if (cmd_r == CMD_FIND) begin
          if (key_match) begin
            hit_nxt    = 1'b1;
            hitval_nxt = val_rd_r;
          end
          if (next_rd_r == NONE) begin
            fin        = 1'b1;
            fin_status = (hit_r || key_match) ? ST_OK : ST_NOTFOUND;
            fin_val    = key_match ? val_rd_r : hitval_r;
            state_nxt  = S_IDLE;
          end else begin
            cur_nxt   = next_rd_r[IW-1:0];
            state_nxt = S_ENT_RD;
          end
        end else if (key_match) begin
          hitval_nxt = val_rd_r;
          nx_nxt     = next_rd_r;
          pv_nxt     = prev_rd_r;
          state_nxt  = S_UNLINK;
        end else if (next_rd_r == NONE) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          cur_nxt   = next_rd_r[IW-1:0];
          state_nxt = S_ENT_RD;
        end
      end
      // drop the entry from its chain
      S_UNLINK: begin
        if (nx_r != NONE) begin
          pvm_we = 1'b1;
          pvm_wa = nx_r[IW-1:0];
          pvm_wd = pv_r;
        end
        if (pv_r != NONE) begin
          nxm_we = 1'b1;
          nxm_wa = pv_r[IW-1:0];
          nxm_wd = nx_r;
        end else begin
          hd_we = 1'b1;
          hd_wd = nx_r;
          nonempty_nxt[bkt_r] = (nx_r != NONE);
        end
        used_nxt[cur_r] = 1'b0;
        if (count_r != '0) count_nxt = count_r - 1'b1;
        fin       = 1'b1;
        fin_val   = hitval_r;
        state_nxt = S_IDLE;
      end
      // lowest non-empty bucket for pop
      S_BSCAN: begin
        if (nonempty_r[bkt_r]) begin
          state_nxt = S_HEAD_RD;
        end else if (bkt_r == LAST_BKT) begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end else begin
          bkt_nxt = bkt_r + 1'b1;
        end
      end
      S_MISC: begin
        if (cmd_r == CMD_CLEAR) begin
          used_nxt     = '0;
          nonempty_nxt = '0;
          count_nxt    = '0;
        end
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, flags and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      used_r      <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      nonempty_r  <= nonempty_nxt;
      out_valid_r <= fin;
    end
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    bkt_r     <= bkt_nxt;
    idx_r     <= idx_nxt;
    cur_r     <= cur_nxt;
    nx_r      <= nx_nxt;
    pv_r      <= pv_nxt;
    hit_r     <= hit_nxt;
    hitval_r  <= hitval_nxt;
    pop_r     <= pop_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_val_r    <= fin_val;
      out_count_r  <= count_nxt;
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (hd_we) head_mem[hd_wa] <= hd_wd;
    head_rd_r <= head_mem[bkt_r];
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[cur_r] <= key_r;
      val_mem[cur_r] <= val_r;
    end
    if (nxm_we) next_mem[nxm_wa] <= nxm_wd;
    if (pvm_we) prev_mem[pvm_wa] <= pvm_wd;
    key_rd_r  <= key_mem[cur_r];
    val_rd_r  <= val_mem[cur_r];
    next_rd_r <= next_mem[cur_r];
    prev_rd_r <= prev_mem[cur_r];
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_value_out   = out_val_r;
  assign out_entry_count = COUNT_W'(out_count_r);

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command did not raise busy");
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(POOL_ENTRIES)) else $error("entry count beyond pool size");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3)) else $error("undefined status code");

endmodule
`default_nettype wire

[tb/sv/chained_hash_table_core_test.sv]
// Self-checking testbench for chained_hash_table_core: directed and random command streams,
// each result checked against a behavioural model of the table. Depends on chtab_pkg.
module chained_hash_table_core_test;
  import chtab_pkg::*;

  localparam int NB = NUM_BUCKETS;
  localparam int NE = DEF_POOL_ENTRIES;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [1:0]         status;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
  } table_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [2:0]             in_cmd;
  logic signed [KEY_W-1:0] in_key;
  logic [VAL_W-1:0]       in_value;
  logic                   out_valid;
  logic [1:0]             out_status;
  logic [VAL_W-1:0]       out_value_out;
  logic [COUNT_W-1:0]     out_entry_count;

  // Model of the table contents
  int unsigned     head_of[NB];
  logic [31:0]     slot_key[NE];
  logic [63:0]     slot_value[NE];
  int unsigned     slot_next[NE];
  int unsigned     slot_prev[NE];
  bit              slot_busy[NE];
  int unsigned     live_count;

  table_result_t   pending_results[$];
  int unsigned     mismatches;
  int unsigned     cycles;
  bit              idle_gaps;
  logic [31:0]     key_pool[24];

  chained_hash_table_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .out_valid(out_valid), .out_status(out_status),
    .out_value_out(out_value_out), .out_entry_count(out_entry_count)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int unsigned bucket_index(logic [31:0] k);
    logic [63:0] wide;
    wide = {{32{k[31]}}, k};
    return int'(wide % 64'd255);
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < NB; i++) head_of[i] = NE;
    for (int i = 0; i < NE; i++) slot_busy[i] = 1'b0;
    live_count = 0;
  endfunction

  function automatic void unlink_slot(int unsigned b, int unsigned e);
    if (slot_next[e] < NE) slot_prev[slot_next[e]] = slot_prev[e];
    if (slot_prev[e] < NE) slot_next[slot_prev[e]] = slot_next[e];
    else head_of[b] = slot_next[e];
    slot_busy[e] = 1'b0;
    if (live_count > 0) live_count--;
  endfunction

  // Apply one command to the model and return the result it should give
  function automatic table_result_t table_apply(logic [2:0] c, logic [31:0] k, logic [63:0] v);
    table_result_t r;
    int unsigned b;
    int unsigned e;
    int unsigned hit;
    r = '0;
    b = bucket_index(k);
    case (c)
      CMD_INSERT: begin
        e = NE;
        for (int i = 0; i < NE; i++)
          if (!slot_busy[i] && e == NE) e = i;
        if (e == NE) begin
          r.status = ST_FULL;
        end else begin
          slot_busy[e] = 1'b1;
          slot_key[e] = k;
          slot_value[e] = v;
          slot_prev[e] = NE;
          slot_next[e] = head_of[b];
          if (head_of[b] < NE) slot_prev[head_of[b]] = e;
          head_of[b] = e;
          live_count++;
        end
      end
      CMD_REMOVE: begin
        r.status = ST_NOTFOUND;
        e = head_of[b];
        while (e < NE) begin
          if (slot_key[e] == k) begin
            r.value = slot_value[e];
            r.status = ST_OK;
            unlink_slot(b, e);
            break;
          end
          e = slot_next[e];
        end
      end
      CMD_FIND: begin
        hit = NE;
        for (e = head_of[b]; e < NE; e = slot_next[e])
          if (slot_key[e] == k) hit = e;
        if (hit < NE) r.value = slot_value[hit];
        else r.status = ST_NOTFOUND;
      end
      CMD_POP: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < NB; i++) begin
          if (head_of[i] < NE) begin
            e = head_of[i];
            r.value = slot_value[e];
            r.status = ST_OK;
            unlink_slot(i, e);
            break;
          end
        end
      end
      CMD_CLEAR: table_reset();
      default: ;
    endcase
    r.count = live_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_value_out !== want.value) report_mismatch("value_out", out_value_out, want.value);
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", out_entry_count, want.count);
      end
    end
  end

  // Cycle budget
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Send one command and hold it until the transfer completes
  task automatic send_cmd(input logic [2:0] c, input logic [31:0] k, input logic [63:0] v);
    int unsigned gap;
    gap = gap_length();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_cmd = c;
    in_key = k;
    in_value = v;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(table_apply(c, k, v));
  endtask

  // Hold off until every expected result has come
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 23)];
    return $urandom;
  endfunction

  task automatic test_basic_ops();
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_FIND, 32'h7fffffff, 0);
    send_cmd(CMD_REMOVE, 32'h80000000, 0);
    send_cmd(CMD_INSERT, 32'h7fffffff, 64'hffff_ffff_ffff_ffff);
    send_cmd(CMD_INSERT, 32'h80000000, 64'h0);
    send_cmd(CMD_INSERT, 32'hffffffff, 64'h8000_0000_0000_0001);
    send_cmd(CMD_FIND, 32'h7fffffff, 0);
    send_cmd(CMD_FIND, 32'h80000000, 0);
    send_cmd(CMD_REMOVE, 32'hffffffff, 0);
    // unknown commands leave the table alone
    send_cmd(3'd5, 32'h7fffffff, rand_value());
    send_cmd(3'd6, 0, rand_value());
    send_cmd(3'd7, 32'h80000000, rand_value());
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_CLEAR, 0, 0);
    send_cmd(CMD_FIND, 32'h80000000, 0);
    drain();
  endtask

  task automatic test_duplicates_and_chains();
    // same key twice, then keys sharing a bucket
    send_cmd(CMD_INSERT, 32'd17, 64'h1111);
    send_cmd(CMD_INSERT, 32'd17, 64'h2222);
    send_cmd(CMD_INSERT, 32'd272, 64'h3333);
    send_cmd(CMD_INSERT, 32'd527, 64'h4444);
    send_cmd(CMD_FIND, 32'd17, 0);
    send_cmd(CMD_REMOVE, 32'd272, 0);
    send_cmd(CMD_REMOVE, 32'd17, 0);
    send_cmd(CMD_FIND, 32'd17, 0);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_POP, 0, 0);
    drain();
  endtask

  task automatic test_full_pool();
    send_cmd(CMD_CLEAR, 0, 0);
    for (int i = 0; i < NE; i++) send_cmd(CMD_INSERT, pick_key(), rand_value());
    send_cmd(CMD_INSERT, 32'd5, rand_value());
    send_cmd(CMD_REMOVE, pick_key(), 0);
    send_cmd(CMD_POP, 0, 0);
    send_cmd(CMD_INSERT, 32'd5, rand_value());
    send_cmd(CMD_INSERT, 32'd6, rand_value());
    send_cmd(CMD_FIND, 32'd5, 0);
    send_cmd(CMD_CLEAR, 0, 0);
    drain();
  endtask

  task automatic test_random_mix(input int unsigned n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) send_cmd(CMD_INSERT, pick_key(), rand_value());
      else if (r < 60) send_cmd(CMD_REMOVE, pick_key(), rand_value());
      else if (r < 85) send_cmd(CMD_FIND, pick_key(), rand_value());
      else if (r < 95) send_cmd(CMD_POP, $urandom, rand_value());
      else if (r < 97) send_cmd(CMD_CLEAR, $urandom, rand_value());
      else send_cmd(3'($urandom_range(5, 7)), $urandom, rand_value());
      if (i % 150 == 149) drain();
    end
    drain();
  endtask

  initial begin
    start = 1'b0;
    in_cmd = '0;
    in_key = '0;
    in_value = '0;
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    idle_gaps = 1'b0;
    table_reset();
    key_pool = '{32'd0, 32'd1, 32'hffffffff, 32'd255, 32'd510, 32'hffffff00,
                 32'h7fffffff, 32'h80000000, 32'd2, 32'd257, 32'd17, 32'd272,
                 32'hfffffffe, 32'd1000, 32'd1255, 32'h5555aaaa, 32'haaaa5555,
                 32'd254, 32'd509, 32'h12345678, 32'hdeadbeef, 32'd3, 32'd258, 32'd64};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_ops();
    idle_gaps = 1'b1;
    test_duplicates_and_chains();
    test_full_pool();
    idle_gaps = 1'b0;
    test_random_mix(150);
    idle_gaps = 1'b1;
    test_random_mix(320);

    drain();
    repeat (800) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
